// ----- rtl/bottom_k_smallest_keeper_macros.svh -----
// Assertion macros for the checker file of the bottom-k keeper.
// Every macro expects signals named clk and rst_n in the calling scope.
`ifndef BOTTOM_K_SMALLEST_KEEPER_MACROS_SVH
`define BOTTOM_K_SMALLEST_KEEPER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BKSK_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BKSK_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bksk_pkg.sv -----
package bksk_pkg;

    localparam int VALUE_W       = 64;
    localparam int CAP_W         = 7;
    localparam int DEPTH_DEFAULT = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    // Sequencer states of the keeper.
    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_RM_RD,
        S_RM_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_SORT_RD,
        S_SORT_SWP,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_HOLD
    } state_t;

endpackage

// ----- rtl/bksk_if.sv -----
// Request channel carrying one offered value or a drain command.
interface bksk_in_if;
    import bksk_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

// Result channel carrying one held value of a drain run.
interface bksk_out_if;
    import bksk_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] kept_value;
    logic               is_last;

    modport source (output valid, output kept_value, output is_last, input ready);
    modport sink   (input valid, input kept_value, input is_last, output ready);
endinterface

// Write channel for the capacity register.
interface bksk_cfg_if;
    import bksk_pkg::*;

    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/bksk_ram.sv -----
// Simple dual-read RAM: one write port, two read ports, registered read data.
module bksk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- rtl/bottom_k_smallest_keeper.sv -----
// Bottom-k keeper: holds the smallest values of a stream of 64-bit hashes, up to the
// capacity register, as a max-heap in a two-read, one-write RAM with registered read
// data. Every heap level takes a read state, which reads the parent or both children,
// and a compare state, which compares and writes back, so the speed is set by that RAM
// read loop. An update request while below capacity sifts up until the value reaches
// the root or stops below it. On a full store a request first reads the root and, when
// the value is strictly smaller, sifts down from the root. A drain request sorts the
// heap in place by repeated root extraction, then delivers the held values one at a
// time, each held until the result side takes it. Requests are accepted only while the
// keeper is idle, and a drain on an empty store finishes at once without a result. The
// store needs no clearing after reset: only entries below the held count are ever used.
module bottom_k_smallest_keeper #(
    parameter int DEPTH = bksk_pkg::DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    bksk_cfg_if.sink   cfg,
    bksk_in_if.sink    item,
    bksk_out_if.source result
);
    import bksk_pkg::*;

    // Address, count and index widths all follow from the store depth.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;
    localparam int IW = AW + 2;

    state_t state_reg, state_next;

    logic [CW-1:0]      count_reg, count_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic               sort_reg, sort_next;
    logic [AW-1:0]      k_reg, k_next;
    logic [AW-1:0]      hole_reg, hole_next;
    logic [AW-1:0]      end_reg, end_next;
    logic [CW-1:0]      size_reg, size_next;
    logic [VALUE_W-1:0] x_reg, x_next;
    logic [VALUE_W-1:0] kept_value_reg, kept_value_next;
    logic               is_last_reg, is_last_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr_a;
    logic [AW-1:0]      ram_raddr_b;
    logic [VALUE_W-1:0] ram_rdata_a;
    logic [VALUE_W-1:0] ram_rdata_b;

    logic               item_acc;
    logic               result_acc;
    logic [EW-1:0]      cap_ext;
    logic [EW-1:0]      eff_cap;
    logic               room;
    logic [AW-1:0]      hole_m1;
    logic [AW-1:0]      parent;
    logic [IW-1:0]      left_idx;
    logic [IW-1:0]      right_idx;
    logic               has_left;
    logic               has_right;
    logic               pick_right;
    logic [VALUE_W-1:0] child_val;
    logic [AW-1:0]      child_idx;
    logic               parent_lt;
    logic               child_gt;
    logic               root_gt;
    logic               dn_done;
    state_t             dn_done_state;

    function automatic logic [AW-1:0] end_from_count(input logic [CW-1:0] cnt);
        logic [CW-1:0] last;
        last = cnt - CW'(1);
        return last[AW-1:0];
    endfunction

    bksk_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_heap_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    assign item_acc   = item.valid && (state_reg == S_IDLE);
    assign result_acc = result.valid && result.ready;

    // A capacity of zero behaves as one, and anything above the depth saturates.
    always_comb
    begin
        cap_ext = EW'(cap_reg);
        if (cap_reg == '0)
        begin
            eff_cap = EW'(1);
        end
        else if (cap_ext > EW'(DEPTH))
        begin
            eff_cap = EW'(DEPTH);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign room = EW'(count_reg) < eff_cap;

    // Heap navigation. Children are compared against the live heap size, which
    // shrinks by one per extraction while sorting.
    assign hole_m1   = hole_reg - AW'(1);
    assign parent    = hole_m1 >> 1;
    assign left_idx  = {1'b0, hole_reg, 1'b1};
    assign right_idx = left_idx + IW'(1);
    assign has_left  = left_idx < IW'(size_reg);
    assign has_right = right_idx < IW'(size_reg);

    assign pick_right = has_right && (ram_rdata_b > ram_rdata_a);
    assign child_val  = pick_right ? ram_rdata_b : ram_rdata_a;
    assign child_idx  = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

    assign parent_lt = ram_rdata_a < x_reg;
    assign child_gt  = child_val > x_reg;
    assign root_gt   = x_reg < ram_rdata_a;

    // The sift-down has placed its value and the hole is closed.
    assign dn_done = ((state_reg == S_DN_RD) && !has_left)
                  || ((state_reg == S_DN_CMP) && !child_gt);

    always_comb
    begin
        if (!sort_reg)
        begin
            dn_done_state = S_IDLE;
        end
        else if (end_reg == AW'(1))
        begin
            dn_done_state = S_OUT_RD;
        end
        else
        begin
            dn_done_state = S_SORT_RD;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    if (!item.mode)
                    begin
                        if (room)
                        begin
                            state_next = S_UP_RD;
                        end
                        else if (count_reg != '0)
                        begin
                            state_next = S_RM_RD;
                        end
                    end
                    else if (count_reg == CW'(1))
                    begin
                        state_next = S_OUT_RD;
                    end
                    else if (count_reg != '0)
                    begin
                        state_next = S_SORT_RD;
                    end
                end
            end
            S_UP_RD:
            begin
                state_next = (hole_reg == '0) ? S_IDLE : S_UP_CMP;
            end
            S_UP_CMP:
            begin
                state_next = parent_lt ? S_UP_RD : S_IDLE;
            end
            S_RM_RD:
            begin
                state_next = S_RM_CMP;
            end
            S_RM_CMP:
            begin
                state_next = root_gt ? S_DN_RD : S_IDLE;
            end
            S_DN_RD:
            begin
                state_next = has_left ? S_DN_CMP : dn_done_state;
            end
            S_DN_CMP:
            begin
                state_next = child_gt ? S_DN_RD : dn_done_state;
            end
            S_SORT_RD:
            begin
                state_next = S_SORT_SWP;
            end
            S_SORT_SWP:
            begin
                state_next = S_DN_RD;
            end
            S_OUT_RD:
            begin
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                state_next = S_OUT_HOLD;
            end
            S_OUT_HOLD:
            begin
                if (result_acc)
                begin
                    state_next = is_last_reg ? S_IDLE : S_OUT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory port controls. Whenever a write meets a read of the same entry in one
    // cycle, that read data is never used, and a write is always visible to the read
    // issued after it.
    always_comb
    begin
        ram_we      = 1'b0;
        ram_waddr   = hole_reg;
        ram_wdata   = x_reg;
        ram_raddr_a = '0;
        ram_raddr_b = '0;
        case (state_reg)
            S_UP_RD:
            begin
                if (hole_reg == '0)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_raddr_a = parent;
                end
            end
            S_UP_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = parent_lt ? ram_rdata_a : x_reg;
            end
            S_DN_RD:
            begin
                if (has_left)
                begin
                    ram_raddr_a = left_idx[AW-1:0];
                    ram_raddr_b = right_idx[AW-1:0];
                end
                else
                begin
                    ram_we = 1'b1;
                end
            end
            S_DN_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = child_gt ? child_val : x_reg;
            end
            S_SORT_RD:
            begin
                ram_raddr_a = end_reg;
            end
            S_SORT_SWP:
            begin
                // The current maximum moves to the end of the shrinking heap.
                ram_we    = 1'b1;
                ram_waddr = end_reg;
                ram_wdata = ram_rdata_b;
            end
            S_OUT_RD:
            begin
                ram_raddr_a = k_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign item.ready        = (state_reg == S_IDLE);
    assign result.valid      = (state_reg == S_OUT_HOLD);
    assign result.kept_value = kept_value_reg;
    assign result.is_last    = is_last_reg;
    assign cfg.ready         = 1'b1;

    // Datapath and counters.
    always_comb
    begin
        count_next      = count_reg;
        cap_next        = cap_reg;
        sort_next       = sort_reg;
        k_next          = k_reg;
        hole_next       = hole_reg;
        end_next        = end_reg;
        size_next       = size_reg;
        x_next          = x_reg;
        kept_value_next = kept_value_reg;
        is_last_next    = is_last_reg;

        if (cfg.valid)
        begin
            cap_next = cfg.data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    x_next    = item.value;
                    sort_next = 1'b0;
                    k_next    = '0;
                    if (!item.mode)
                    begin
                        if (room)
                        begin
                            hole_next  = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (count_reg > CW'(1))
                    begin
                        sort_next = 1'b1;
                        end_next  = end_from_count(count_reg);
                    end
                end
            end
            S_UP_CMP:
            begin
                if (parent_lt)
                begin
                    hole_next = parent;
                end
            end
            S_RM_CMP:
            begin
                hole_next = '0;
                size_next = count_reg;
            end
            S_DN_CMP:
            begin
                if (child_gt)
                begin
                    hole_next = child_idx;
                end
            end
            S_SORT_SWP:
            begin
                x_next    = ram_rdata_a;
                hole_next = '0;
                size_next = CW'(end_reg);
            end
            S_OUT_LD:
            begin
                kept_value_next = ram_rdata_a;
                is_last_next    = (CW'(k_reg) == (count_reg - CW'(1)));
            end
            S_OUT_HOLD:
            begin
                if (result_acc)
                begin
                    if (is_last_reg)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        k_next = k_reg + AW'(1);
                    end
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase

        if (dn_done && sort_reg && (end_reg != AW'(1)))
        begin
            end_next = end_reg - AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
            sort_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
            sort_reg  <= sort_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hole_reg       <= hole_next;
        end_reg        <= end_next;
        size_reg       <= size_next;
        x_reg          <= x_next;
        kept_value_reg <= kept_value_next;
        is_last_reg    <= is_last_next;
    end

endmodule

// ----- rtl/bksk_checker.sv -----
`include "bottom_k_smallest_keeper_macros.svh"

// Port-level checks of the keeper's request and result channels.
module bksk_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic                         result_is_last,
    input logic [bksk_pkg::VALUE_W-1:0] result_kept_value
);

    // A stalled result must stay offered and unchanged.
    `BKSK_ASSERT_NXT(a_result_held, result_valid && !result_ready, result_valid && $stable(result_kept_value) && $stable(result_is_last), "stalled result dropped or changed")

    // No request is taken while a drain result is offered.
    `BKSK_ASSERT_IMP(a_no_request_in_drain, result_valid, !item_ready, "request taken during a drain")

    // After a result that is not the last, the drain carries on.
    `BKSK_ASSERT_NXT(a_drain_continues, result_valid && result_ready && !result_is_last, !item_ready, "drain ended before its last result")

    // A result never appears in the cycle after a request is taken.
    `BKSK_ASSERT_NXT(a_no_instant_result, item_valid && item_ready, !result_valid, "result appeared directly after a request")

endmodule

bind bottom_k_smallest_keeper bksk_checker u_bksk_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_is_last    (result.is_last),
    .result_kept_value (result.kept_value)
);
